// ===== rtl/core/cfcm_pkg.sv =====
package cfcm_pkg;

    localparam int DEF_COUNT_WIDTH = 16;
    localparam int LEVEL_W         = 8;
    localparam int THR_W           = 7;
    localparam int NEED_W          = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 8'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX_NEXT = 8'd101;

    localparam logic [THR_W-1:0]   RST_LOW_THRESHOLD    = 7'd10;
    localparam logic [LEVEL_W-1:0] RST_FULL_THRESHOLD   = 8'd100;
    localparam logic [THR_W-1:0]   RST_HIGH_START_LEVEL = 7'd70;
    localparam logic [THR_W-1:0]   RST_NEAR_FULL_LEVEL  = 7'd90;
    localparam logic [LEVEL_W-1:0] RST_RATE_PER_PERCENT = 8'd120;
    localparam logic [LEVEL_W-1:0] RST_BASE_TIME        = 8'd150;
    localparam logic [LEVEL_W-1:0] RST_NORMAL_FACTOR    = 8'd50;
    localparam logic [LEVEL_W-1:0] RST_MIN_CONFIRM      = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THRESHOLD    = 3'd0,
        CFG_FULL_THRESHOLD   = 3'd1,
        CFG_HIGH_START_LEVEL = 3'd2,
        CFG_NEAR_FULL_LEVEL  = 3'd3,
        CFG_RATE_PER_PERCENT = 3'd4,
        CFG_BASE_TIME        = 3'd5,
        CFG_NORMAL_FACTOR    = 3'd6,
        CFG_MIN_CONFIRM      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]   low_threshold;
        logic [LEVEL_W-1:0] full_threshold;
        logic [THR_W-1:0]   high_start_level;
        logic [THR_W-1:0]   near_full_level;
        logic [LEVEL_W-1:0] rate_per_percent;
        logic [LEVEL_W-1:0] base_time;
        logic [LEVEL_W-1:0] normal_factor;
        logic [LEVEL_W-1:0] min_confirm;
    } t_cfg;

    typedef struct packed {
        logic               charger_present;
        logic [LEVEL_W-1:0] level_now;
        logic [LEVEL_W-1:0] level_filtered;
    } t_item;

    typedef struct packed {
        logic               led_red;
        logic               led_green;
        logic [LEVEL_W-1:0] shown_level;
        logic               is_charging;
        logic               is_full;
        logic               charge_changed;
        logic               level_report;
        logic               save_request;
        logic [LEVEL_W-1:0] save_value;
    } t_result;

    typedef struct packed {
        logic               charger_present;
        logic               now_ge_full;
        logic               filt_lt_full;
        logic               filt_le_low;
        logic [LEVEL_W-1:0] level_now;
        logic [LEVEL_W-1:0] level_filtered;
    } t_cmd;

endpackage

// ===== rtl/core/charge_full_confirm_monitor_core.sv =====
// path: an item is registered in the command queue, and its result in the result queue, before it can be popped
// throughput: one item per cycle while the result queue is not full, set by the state update of the back end
// (one 8x8 multiply for the required time, then the count compare)
// reset: synchronous, active low; registers return to their defaults, all state to zero,
// both queues empty; no clearing pass, items are taken as soon as reset is released
module charge_full_confirm_monitor_core #(
    parameter int COUNT_WIDTH = cfcm_pkg::DEF_COUNT_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  cfcm_pkg::t_item                  i_item,
    output logic                             empty,
    input  logic                             pop,
    output cfcm_pkg::t_result                o_result,
    input  logic                             valid,
    output logic                             ready,
    input  logic [cfcm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cfcm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cfcm_pkg::*;

    t_cfg    w_cfg;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    t_result w_res_in;
    logic    w_cmd_push;
    logic    w_cmd_full;
    logic    w_cmd_empty;
    logic    w_cmd_pop;
    logic    w_res_push;
    logic    w_res_full;

    cfcm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .valid       (valid),
        .ready       (ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    cfcm_front u_front (
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .i_cfg    (w_cfg),
        .i_q_full (w_cmd_full),
        .o_q_push (w_cmd_push),
        .o_cmd    (w_cmd_in)
    );

    cfcm_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    cfcm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (!w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    cfcm_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    a_leds_follow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.is_charging) |->
            (o_result.led_green == o_result.is_full) && (o_result.led_red == !o_result.is_full))
        else $error("led state disagrees with full flag while charging");

    a_unplug_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.save_request) |->
            (o_result.level_report && o_result.charge_changed && !o_result.is_charging
             && !o_result.led_green && (o_result.save_value == o_result.shown_level)))
        else $error("unplug item inconsistent");

    a_save_value_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.save_request) |-> (o_result.save_value == '0))
        else $error("save value set without save request");

endmodule

// ===== rtl/core/cfcm_fifo.sv =====
module cfcm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == CNT_FULL);
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/cfcm_cfg.sv =====
module cfcm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             valid,
    output logic                             ready,
    input  logic [cfcm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cfcm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output cfcm_pkg::t_cfg                   o_cfg
);
    import cfcm_pkg::*;

    t_cfg r_cfg, n_cfg;

    assign ready = 1'b1;
    assign o_cfg = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOW_THRESHOLD:    n_cfg.low_threshold    = i_cfg_data[THR_W-1:0];
                CFG_FULL_THRESHOLD:   n_cfg.full_threshold   = i_cfg_data;
                CFG_HIGH_START_LEVEL: n_cfg.high_start_level = i_cfg_data[THR_W-1:0];
                CFG_NEAR_FULL_LEVEL:  n_cfg.near_full_level  = i_cfg_data[THR_W-1:0];
                CFG_RATE_PER_PERCENT: n_cfg.rate_per_percent = i_cfg_data;
                CFG_BASE_TIME:        n_cfg.base_time        = i_cfg_data;
                CFG_NORMAL_FACTOR:    n_cfg.normal_factor    = i_cfg_data;
                CFG_MIN_CONFIRM:      n_cfg.min_confirm      = i_cfg_data;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold    <= RST_LOW_THRESHOLD;
            r_cfg.full_threshold   <= RST_FULL_THRESHOLD;
            r_cfg.high_start_level <= RST_HIGH_START_LEVEL;
            r_cfg.near_full_level  <= RST_NEAR_FULL_LEVEL;
            r_cfg.rate_per_percent <= RST_RATE_PER_PERCENT;
            r_cfg.base_time        <= RST_BASE_TIME;
            r_cfg.normal_factor    <= RST_NORMAL_FACTOR;
            r_cfg.min_confirm      <= RST_MIN_CONFIRM;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/core/cfcm_front.sv =====
module cfcm_front (
    input  logic              i_push,
    output logic              o_full,
    input  cfcm_pkg::t_item   i_item,
    input  cfcm_pkg::t_cfg    i_cfg,
    input  logic              i_q_full,
    output logic              o_q_push,
    output cfcm_pkg::t_cmd    o_cmd
);
    import cfcm_pkg::*;

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    // level compares against thresholds, done once at intake
    always_comb begin
        o_cmd.charger_present = i_item.charger_present;
        o_cmd.now_ge_full     = (i_item.level_now >= i_cfg.full_threshold);
        o_cmd.filt_lt_full    = (i_item.level_filtered < i_cfg.full_threshold);
        o_cmd.filt_le_low     = (i_item.level_filtered <= {1'b0, i_cfg.low_threshold});
        o_cmd.level_now       = i_item.level_now;
        o_cmd.level_filtered  = i_item.level_filtered;
    end

endmodule

// ===== rtl/core/cfcm_back.sv =====
module cfcm_back #(
    parameter int COUNT_WIDTH = cfcm_pkg::DEF_COUNT_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cfcm_pkg::t_cfg      i_cfg,
    input  logic                i_cmd_valid,
    input  cfcm_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output cfcm_pkg::t_result   o_res
);
    import cfcm_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > NEED_W) ? COUNT_WIDTH : NEED_W;

    logic                   r_chg, n_chg;
    logic                   r_full, n_full;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [LEVEL_W-1:0]     r_start, n_start;
    logic [LEVEL_W-1:0]     r_known, n_known;
    logic [LEVEL_W-1:0]     r_stored, n_stored;
    logic [LEVEL_W-1:0]     r_shown, n_shown;
    logic                   r_red, n_red;
    logic                   r_green, n_green;

    logic                   w_step;
    logic                   w_plug;
    logic [LEVEL_W-1:0]     w_start_eff;
    logic                   w_use_start;
    logic                   w_use_near;
    logic [LEVEL_W-1:0]     w_mul_a;
    logic [LEVEL_W-1:0]     w_mul_b;
    logic [NEED_W-1:0]      w_prod;
    logic [NEED_W-1:0]      w_need;
    logic                   w_full_pre;
    logic [COUNT_WIDTH-1:0] w_cnt0;
    logic [COUNT_WIDTH-1:0] w_cnt1;
    logic                   w_changed;
    logic                   w_report;

    assign w_step     = i_cmd_valid && !i_res_full;
    assign o_cmd_pop  = w_step;
    assign o_res_push = w_step;

    assign w_plug      = !r_chg;
    assign w_start_eff = w_plug ? r_known : r_start;
    assign w_use_start = (w_start_eff >= {1'b0, i_cfg.high_start_level})
                      && (w_start_eff <= LEVEL_MAX);
    assign w_use_near  = (r_known >= {1'b0, i_cfg.near_full_level})
                      && (r_known <= LEVEL_MAX);

    // required confirmation time
    always_comb begin
        if (w_use_start) begin
            w_mul_a = LEVEL_MAX - w_start_eff;
            w_mul_b = i_cfg.rate_per_percent;
        end else if (w_use_near) begin
            w_mul_a = i_cfg.base_time;
            w_mul_b = LEVEL_MAX_NEXT - r_known;
        end else begin
            w_mul_a = i_cfg.base_time;
            w_mul_b = i_cfg.normal_factor;
        end
    end

    assign w_prod = {8'd0, w_mul_a} * {8'd0, w_mul_b};
    assign w_need = (w_prod < {8'd0, i_cfg.min_confirm}) ? {8'd0, i_cfg.min_confirm} : w_prod;

    assign w_full_pre = w_plug ? (r_full && i_cmd.now_ge_full) : r_full;
    assign w_cnt0     = w_plug ? '0 : r_cnt;
    assign w_cnt1     = (w_cnt0 == {COUNT_WIDTH{1'b1}}) ? w_cnt0 : w_cnt0 + 1'b1;

    always_comb begin
        n_chg     = r_chg;
        n_full    = r_full;
        n_cnt     = r_cnt;
        n_start   = r_start;
        n_known   = r_known;
        n_stored  = r_stored;
        n_shown   = r_shown;
        n_red     = r_red;
        n_green   = r_green;
        w_changed = 1'b0;
        w_report  = 1'b0;
        if (i_cmd.charger_present) begin
            n_full  = w_full_pre;
            n_cnt   = w_cnt0;
            n_start = w_start_eff;
            if (!w_full_pre) begin
                n_shown = i_cmd.level_now;
                if (i_cmd.now_ge_full) begin
                    if (CMP_W'(w_cnt1) >= CMP_W'(w_need)) begin
                        n_full = 1'b1;
                        n_cnt  = '0;
                    end else begin
                        n_cnt = w_cnt1;
                    end
                end else begin
                    n_cnt  = '0;
                    n_full = 1'b0;
                end
            end
            if (w_plug) begin
                n_known   = r_stored;
                n_chg     = 1'b1;
                w_changed = 1'b1;
            end
            n_green = n_full;
            n_red   = !n_full;
        end else if (r_chg) begin
            n_chg     = 1'b0;
            n_shown   = i_cmd.level_filtered;
            n_start   = '0;
            w_changed = 1'b1;
            w_report  = 1'b1;
            n_full    = r_full && !i_cmd.filt_lt_full;
            n_stored  = i_cmd.level_filtered;
            n_green   = 1'b0;
            n_red     = i_cmd.filt_le_low;
        end
    end

    always_comb begin
        o_res.led_red        = n_red;
        o_res.led_green      = n_green;
        o_res.shown_level    = n_shown;
        o_res.is_charging    = n_chg;
        o_res.is_full        = n_full;
        o_res.charge_changed = w_changed;
        o_res.level_report   = w_report;
        o_res.save_request   = w_report;
        o_res.save_value     = w_report ? i_cmd.level_filtered : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg    <= 1'b0;
            r_full   <= 1'b0;
            r_cnt    <= '0;
            r_start  <= '0;
            r_known  <= '0;
            r_stored <= '0;
            r_shown  <= '0;
            r_red    <= 1'b0;
            r_green  <= 1'b0;
        end else if (w_step) begin
            r_chg    <= n_chg;
            r_full   <= n_full;
            r_cnt    <= n_cnt;
            r_start  <= n_start;
            r_known  <= n_known;
            r_stored <= n_stored;
            r_shown  <= n_shown;
            r_red    <= n_red;
            r_green  <= n_green;
        end
    end

endmodule
